// ===== rtl/core/keyword_triple_detector_macros.svh =====
// ----------------------------------------------------------------------------
// keyword_triple_detector_macros.svh
// Assertion shorthands used by the checker file of the detector.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_TRIPLE_DETECTOR_MACROS_SVH
`define KEYWORD_TRIPLE_DETECTOR_MACROS_SVH

// Clocked on aclk, muted while aresetn is low.
`define KTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked on aclk, also checked across reset.
`define KTD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/core/ktd_pkg.sv =====
// ----------------------------------------------------------------------------
// ktd_pkg
// Types, constants and character classification for the keyword triple
// detector.
// ----------------------------------------------------------------------------
package ktd_pkg;

    localparam int WORD_COUNT  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] LEN_SAT = 3'd6;
    // Keyword lengths: "is", "not", "empty"
    localparam logic [2:0] WORD_LEN [WORD_COUNT] = '{3'd2, 3'd3, 3'd5};

    // Bit p of row k: the character equals letter p of keyword k.
    typedef logic [WORD_COUNT-1:0][7:0] hit_vec_t;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } quote_t;

    typedef enum logic [1:0] {
        WC_NONE  = 2'd0,
        WC_IS    = 2'd1,
        WC_NOT   = 2'd2,
        WC_EMPTY = 2'd3
    } word_class_t;

    // One classified word handed from the front to the back.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
        logic       squote;
        logic       dquote;
        logic       bslash;
        logic       starts;
        logic       conts;
        hit_vec_t   hits;
    } ktd_item_t;

    function automatic logic is_letter(input logic [7:0] ch);
        return ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= "0") && (ch <= "9");
    endfunction

    function automatic hit_vec_t char_hits(input logic [7:0] ch);
        hit_vec_t h;
        h       = '0;
        h[0][0] = (ch == "i");
        h[0][1] = (ch == "s");
        h[1][0] = (ch == "n");
        h[1][1] = (ch == "o");
        h[1][2] = (ch == "t");
        h[2][0] = (ch == "e");
        h[2][1] = (ch == "m");
        h[2][2] = (ch == "p");
        h[2][3] = (ch == "t");
        h[2][4] = (ch == "y");
        return h;
    endfunction

endpackage

// ===== rtl/core/keyword_triple_detector.sv =====
// ----------------------------------------------------------------------------
// keyword_triple_detector: one character per clock while neither side stalls.
// An accepted word is written into the queue, then popped into the output
// register, which raises m_valid; sustained rate is one word a cycle while
// m_ready holds, set by the scanner update in the back end.
// A four-entry queue lets input keep flowing for four words while m_ is stalled.
// Synchronous active-low reset empties the queue, drops m_valid, clears scanner.
// ----------------------------------------------------------------------------
module keyword_triple_detector (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_char_byte,
    input  logic       s_last_char,
    input  logic       s_valid,
    output logic       s_ready,
    output logic [7:0] m_out_byte,
    output logic       m_end_of_expr,
    output logic       m_rejected,
    output logic       m_valid,
    input  logic       m_ready
);
    import ktd_pkg::*;

    // Classified word from the front into the queue.
    logic      q_wr_valid;
    logic      q_wr_ready;
    ktd_item_t q_wr_item;

    // Queue head into the scanner.
    logic      q_rd_valid;
    logic      q_rd_ready;
    ktd_item_t q_rd_item;

    // Front: decode quote, backslash and identifier classes plus the per-keyword
    // letter hits, so the back end compares nothing wider than a few bits.
    ktd_front u_front (
        .s_char_byte (s_char_byte),
        .s_last_char (s_last_char),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .wr_valid    (q_wr_valid),
        .wr_ready    (q_wr_ready),
        .wr_item     (q_wr_item)
    );

    // Queue: hold classified words so front and back stall independently.
    ktd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_item  (q_wr_item),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_item  (q_rd_item)
    );

    // Back: advance the quote/identifier scanner, shift finished identifiers
    // through the two-deep keyword window, latch the sticky reject flag and
    // report it on the last character. The output register pops a new word
    // whenever it is empty or being drained in the same cycle.
    ktd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rd_valid      (q_rd_valid),
        .rd_ready      (q_rd_ready),
        .rd_item       (q_rd_item),
        .m_out_byte    (m_out_byte),
        .m_end_of_expr (m_end_of_expr),
        .m_rejected    (m_rejected),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

endmodule

// ===== rtl/core/ktd_front.sv =====
// ----------------------------------------------------------------------------
// ktd_front
// Accepts characters and classifies them for the scanner.
// ----------------------------------------------------------------------------
module ktd_front (
    input  logic              [7:0] s_char_byte,
    input  logic                    s_last_char,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    wr_valid,
    input  logic                    wr_ready,
    output ktd_pkg::ktd_item_t      wr_item
);
    import ktd_pkg::*;

    always_comb begin
        wr_item.char_byte = s_char_byte;
        wr_item.last_char = s_last_char;
        wr_item.squote    = (s_char_byte == "'");
        wr_item.dquote    = (s_char_byte == "\"");
        wr_item.bslash    = (s_char_byte == "\\");
        wr_item.starts    = is_letter(s_char_byte) || (s_char_byte == "_");
        wr_item.conts     = is_letter(s_char_byte) || is_digit(s_char_byte)
                            || (s_char_byte == "_") || (s_char_byte == "-");
        wr_item.hits      = char_hits(s_char_byte);
    end

    assign wr_valid = s_valid;
    assign s_ready  = wr_ready;

endmodule

// ===== rtl/core/ktd_queue.sv =====
// ----------------------------------------------------------------------------
// ktd_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module ktd_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  ktd_pkg::ktd_item_t wr_item,
    output logic               rd_valid,
    input  logic               rd_ready,
    output ktd_pkg::ktd_item_t rd_item
);
    import ktd_pkg::*;

    ktd_item_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                push, pop;

    assign wr_ready = (count_reg != QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/core/ktd_back.sv =====
// ----------------------------------------------------------------------------
// ktd_back
// Quote and identifier scanner with keyword window and output register.
// ----------------------------------------------------------------------------
module ktd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rd_valid,
    output logic               rd_ready,
    input  ktd_pkg::ktd_item_t rd_item,
    output logic         [7:0] m_out_byte,
    output logic               m_end_of_expr,
    output logic               m_rejected,
    output logic               m_valid,
    input  logic               m_ready
);
    import ktd_pkg::*;

    typedef struct packed {
        quote_t      quote;
        logic        esc;
        logic        in_tok;
        logic [2:0]  len;
        logic [2:0]  match;
        word_class_t prior0;
        word_class_t prior1;
        logic        seen;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        quote:  Q_NONE,
        esc:    1'b0,
        in_tok: 1'b0,
        len:    3'd0,
        match:  3'b111,
        prior0: WC_NONE,
        prior1: WC_NONE,
        seen:   1'b0
    };

    scan_state_t state_reg, state_next;
    logic [7:0]  byte_reg;
    logic        end_reg;
    logic        rej_reg, rej_next;
    logic        valid_reg;
    logic        pop;

    function automatic scan_state_t extend(input scan_state_t s, input hit_vec_t h);
        scan_state_t r;
        r = s;
        for (int k = 0; k < WORD_COUNT; k++) begin
            if (!h[k][s.len]) begin
                r.match[k] = 1'b0;
            end
        end
        if (s.len < LEN_SAT) begin
            r.len = s.len + 3'd1;
        end
        return r;
    endfunction

    function automatic scan_state_t finish(input scan_state_t s);
        scan_state_t r;
        word_class_t cls;
        r   = s;
        cls = WC_NONE;
        if (s.match[0] && (s.len == WORD_LEN[0])) cls = WC_IS;
        if (s.match[1] && (s.len == WORD_LEN[1])) cls = WC_NOT;
        if (s.match[2] && (s.len == WORD_LEN[2])) cls = WC_EMPTY;
        if ((s.prior0 == WC_IS) && (s.prior1 == WC_NOT) && (cls == WC_EMPTY)) begin
            r.seen = 1'b1;
        end
        r.prior0 = s.prior1;
        r.prior1 = cls;
        r.in_tok = 1'b0;
        r.len    = 3'd0;
        r.match  = 3'b111;
        return r;
    endfunction

    assign pop      = rd_valid && (!valid_reg || m_ready);
    assign rd_ready = !valid_reg || m_ready;

    always_comb begin
        scan_state_t st;
        logic        rej;
        st  = state_reg;
        rej = 1'b0;
        if (st.quote != Q_NONE) begin
            if (st.esc) begin
                st.esc = 1'b0;
            end else if (rd_item.bslash) begin
                st.esc = 1'b1;
            end else if (((st.quote == Q_SINGLE) && rd_item.squote) ||
                         ((st.quote == Q_DOUBLE) && rd_item.dquote)) begin
                st.quote = Q_NONE;
            end
        end else if (st.in_tok && rd_item.conts) begin
            st = extend(st, rd_item.hits);
        end else begin
            if (st.in_tok) begin
                st = finish(st);
            end
            if (rd_item.squote) begin
                st.quote = Q_SINGLE;
            end else if (rd_item.dquote) begin
                st.quote = Q_DOUBLE;
            end else if (rd_item.starts) begin
                st.in_tok = 1'b1;
                st.len    = 3'd0;
                st.match  = 3'b111;
                st        = extend(st, rd_item.hits);
            end
        end
        if (rd_item.last_char) begin
            if (st.in_tok) begin
                st = finish(st);
            end
            rej = st.seen;
            st  = SCAN_RESET;
        end
        state_next = st;
        rej_next   = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_RESET;
            valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            byte_reg <= rd_item.char_byte;
            end_reg  <= rd_item.last_char;
            rej_reg  <= rej_next;
        end
    end

    assign m_out_byte    = byte_reg;
    assign m_end_of_expr = end_reg;
    assign m_rejected    = rej_reg;
    assign m_valid       = valid_reg;

endmodule

// ===== rtl/core/ktd_checker.sv =====
// ----------------------------------------------------------------------------
// ktd_checker
// Port-level checks on the keyword triple detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyword_triple_detector_macros.svh"

module ktd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic [7:0] s_char_byte,
    input logic       s_last_char,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] m_out_byte,
    input logic       m_end_of_expr,
    input logic       m_rejected,
    input logic       m_valid,
    input logic       m_ready
);

    // A stalled result stays offered.
    `KTD_ASSERT(a_hold_valid, m_valid && !m_ready |=> m_valid, "m_valid dropped while stalled")

    // A stalled result keeps its payload.
    `KTD_ASSERT(a_hold_data, m_valid && !m_ready |=> $stable({m_out_byte, m_end_of_expr, m_rejected}), "m_ payload changed while stalled")

    // Reject is only reported on the final character.
    `KTD_ASSERT(a_rej_on_end, m_valid && m_rejected |-> m_end_of_expr, "m_rejected without m_end_of_expr")

    // Reset empties the output register.
    `KTD_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "m_valid high after reset")

endmodule

bind keyword_triple_detector ktd_checker u_ktd_checker (.*);

// ===== bench/keyword_scan_checker.sv =====
// ----------------------------------------------------------------------------
// keyword_scan_checker
// Watches both channels of the keyword triple detector. It scans every
// accepted input word with its own copy of the scanner state, queues the
// expected output word, and compares each accepted output word with it.
// ----------------------------------------------------------------------------
module keyword_scan_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_char_byte,
    input  logic       s_last_char,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_end_of_expr,
    input  logic       m_rejected,
    input  logic       m_valid,
    input  logic       m_ready,
    output int         fail_count,
    output int         words_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    import ktd_pkg::*;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [2:0] IDENT_SAT = 3'd6;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_flag;
        logic       reject;
    } scan_word_t;

    scan_word_t  expected_words[$];

    quote_t      quote_mode;
    logic        escape_pending;
    logic        in_ident;
    logic [2:0]  ident_len;
    logic [2:0]  still_prefix;
    word_class_t prev_class [2];
    logic        triple_seen;

    function automatic string keyword_text(input int k);
        case (k)
            0:       return "is";
            1:       return "not";
            default: return "empty";
        endcase
    endfunction

    function automatic logic alpha_char(input logic [7:0] ch);
        return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    endfunction

    function automatic logic ident_head(input logic [7:0] ch);
        return alpha_char(ch) || ch == CH_USCORE;
    endfunction

    function automatic logic ident_body(input logic [7:0] ch);
        return alpha_char(ch) || (ch >= 8'h30 && ch <= 8'h39) ||
               ch == CH_USCORE || ch == CH_DASH;
    endfunction

    task automatic clear_scan();
        quote_mode     = Q_NONE;
        escape_pending = 1'b0;
        in_ident       = 1'b0;
        ident_len      = '0;
        still_prefix   = 3'b111;
        prev_class[0]  = WC_NONE;
        prev_class[1]  = WC_NONE;
        triple_seen    = 1'b0;
    endtask

    // Drop every keyword that the identifier no longer spells a prefix of, and count the character.
    task automatic grow_ident(input logic [7:0] ch);
        string kw;
        int    pos;
        pos = ident_len;
        for (int k = 0; k < 3; k++) begin
            kw = keyword_text(k);
            if (still_prefix[k] && (pos >= kw.len() || kw[pos] != ch))
                still_prefix[k] = 1'b0;
        end
        if (ident_len < IDENT_SAT)
            ident_len = ident_len + 3'd1;
    endtask

    // Classify the finished identifier and advance the two-word window.
    task automatic close_ident();
        word_class_t cls;
        string       kw;
        cls = WC_NONE;
        for (int k = 0; k < 3; k++) begin
            kw = keyword_text(k);
            if (still_prefix[k] && ident_len == kw.len())
                cls = word_class_t'(k + 1);
        end
        if (prev_class[0] == WC_IS && prev_class[1] == WC_NOT && cls == WC_EMPTY)
            triple_seen = 1'b1;
        prev_class[0] = prev_class[1];
        prev_class[1] = cls;
        in_ident      = 1'b0;
        ident_len     = '0;
        still_prefix  = 3'b111;
    endtask

    task automatic scan_char(input logic [7:0] ch, input logic last,
                             output scan_word_t res);
        logic rej;
        rej = 1'b0;
        if (quote_mode != Q_NONE) begin
            if (escape_pending)
                escape_pending = 1'b0;
            else if (ch == CH_BSLASH)
                escape_pending = 1'b1;
            else if ((quote_mode == Q_SINGLE && ch == CH_SQUOTE) ||
                     (quote_mode == Q_DOUBLE && ch == CH_DQUOTE))
                quote_mode = Q_NONE;
        end else if (in_ident && ident_body(ch)) begin
            grow_ident(ch);
        end else begin
            if (in_ident)
                close_ident();
            if (ch == CH_SQUOTE) begin
                quote_mode = Q_SINGLE;
            end else if (ch == CH_DQUOTE) begin
                quote_mode = Q_DOUBLE;
            end else if (ident_head(ch)) begin
                in_ident     = 1'b1;
                ident_len    = '0;
                still_prefix = 3'b111;
                grow_ident(ch);
            end
        end
        if (last) begin
            if (in_ident)
                close_ident();
            rej = triple_seen;
            clear_scan();
        end
        res = '{char_byte: ch, end_flag: last, reject: rej};
    endtask

    always @(posedge aclk) begin
        scan_word_t want;
        scan_word_t got;
        if (!aresetn) begin
            clear_scan();
            expected_words.delete();
            fail_count = 0;
        end else begin
            // A result is registered behind its input, so compare first.
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word byte=%02h end=%0b rej=%0b",
                             $time, m_out_byte, m_end_of_expr, m_rejected);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_out_byte !== want.char_byte) begin
                        $display("%0t: out_byte expected %02h got %02h",
                                 $time, want.char_byte, m_out_byte);
                        fail_count++;
                    end
                    if (m_end_of_expr !== want.end_flag) begin
                        $display("%0t: end_of_expr expected %0b got %0b",
                                 $time, want.end_flag, m_end_of_expr);
                        fail_count++;
                    end
                    if (m_rejected !== want.reject) begin
                        $display("%0t: rejected expected %0b got %0b",
                                 $time, want.reject, m_rejected);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                scan_char(s_char_byte, s_last_char, got);
                expected_words.insert(expected_words.size(), got);
            end
        end
        words_in_flight = expected_words.size();
    end

endmodule

// ===== bench/tb_keyword_triple_detector.sv =====
// ----------------------------------------------------------------------------
// tb_keyword_triple_detector
// Feeds the detector whole expressions, one character per word: a short
// directed set of corner cases, then random expressions built mostly from
// keywords, near misses, identifiers, quoted text and operators. Both
// channels idle at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_keyword_triple_detector;
    timeunit 1ns;
    timeprecision 1ps;

    localparam time        CLK_PERIOD   = 10ns;
    localparam int         ITEM_TARGET  = 450;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         HOLD_EXPR    = 6;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH    = 8'h5C;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic [7:0] s_char_byte = 8'h00;
    logic       s_last_char = 1'b0;
    logic       s_valid     = 1'b0;
    logic       m_ready     = 1'b0;
    logic       s_ready;
    logic [7:0] m_out_byte;
    logic       m_end_of_expr;
    logic       m_rejected;
    logic       m_valid;

    int         fail_count;
    int         words_in_flight;

    // When set, neither side idles: back-to-back words on both channels.
    logic       calm         = 1'b0;
    int         items_sent   = 0;
    int         idle_cycles  = 0;
    int         ready_left   = 0;
    int         expr_count   = 0;
    logic [7:0] expr_q[$];

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    keyword_triple_detector u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_char_byte   (s_char_byte),
        .s_last_char   (s_last_char),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .m_out_byte    (m_out_byte),
        .m_end_of_expr (m_end_of_expr),
        .m_rejected    (m_rejected),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

    keyword_scan_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_char_byte     (s_char_byte),
        .s_last_char     (s_last_char),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .m_out_byte      (m_out_byte),
        .m_end_of_expr   (m_end_of_expr),
        .m_rejected      (m_rejected),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .fail_count      (fail_count),
        .words_in_flight (words_in_flight)
    );

    // Result side: alternate runs of ready with stalls, mostly short ones.
    always @(posedge aclk) begin
        int r;
        if (calm) begin
            m_ready    <= 1'b1;
            ready_left <= 0;
        end else if (ready_left == 0) begin
            if (m_ready) begin
                r = $urandom_range(0, 99);
                m_ready    <= 1'b0;
                ready_left <= (r < 80) ? $urandom_range(0, 2) :
                              (r < 95) ? $urandom_range(3, 9) : $urandom_range(20, 40);
            end else begin
                m_ready    <= 1'b1;
                ready_left <= $urandom_range(0, 29);
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_cycles++;
            end
        end
    end

    // Sender gap: half the words go back to back, a few wait a long time.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    // Enter at a rising edge; return at the edge where the word is accepted.
    task automatic send_word(input logic [7:0] ch, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_char_byte <= ch;
        s_last_char <= last;
        s_valid     <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Append one character to the expression being built.
    task automatic append_byte(input logic [7:0] b);
        expr_q.insert(expr_q.size(), b);
    endtask

    // Send the buffered expression, marking its final character.
    task automatic send_expr();
        for (int i = 0; i < expr_q.size(); i++)
            send_word(expr_q[i], i == expr_q.size() - 1);
        expr_q.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endtask

    function automatic logic [7:0] ident_char(input bit first);
        int r;
        r = first ? $urandom_range(0, 52) : $urandom_range(0, 64);
        if (r < 26) return 8'(8'h61 + r);
        if (r < 52) return 8'(8'h41 + (r - 26));
        if (r == 52) return 8'h5F;
        if (r < 63) return 8'(8'h30 + (r - 53));
        return 8'h2D;
    endfunction

    // Random identifier, long enough now and then to saturate the length.
    task automatic add_ident();
        int n;
        n = $urandom_range(1, 9);
        append_byte(ident_char(1'b1));
        for (int i = 1; i < n; i++)
            append_byte(ident_char(1'b0));
    endtask

    // Quoted text with escapes; about one in twenty is left unterminated.
    task automatic add_quoted();
        logic [7:0] q;
        logic [7:0] b;
        int         n;
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        n = $urandom_range(0, 5);
        append_byte(q);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                append_byte(CH_BSLASH);
                append_byte(8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 2))
                    0:       add_text("is");
                    1:       add_text(" not ");
                    default: begin
                        b = 8'($urandom_range(0, 255));
                        if (b == q || b == CH_BSLASH)
                            b = 8'h6B;
                        append_byte(b);
                    end
                endcase
            end
        end
        if ($urandom_range(0, 19) != 0)
            append_byte(q);
    endtask

    task automatic add_near_miss();
        case ($urandom_range(0, 9))
            0:       add_text("i");
            1:       add_text("no");
            2:       add_text("empt");
            3:       add_text("emptyy");
            4:       add_text("IS");
            5:       add_text("nots");
            6:       add_text("is_");
            7:       add_text("not-");
            8:       add_text("Empty");
            default: add_text("isnot");
        endcase
    endtask

    task automatic add_operator();
        case ($urandom_range(0, 7))
            0:       add_text("==");
            1:       add_text("(");
            2:       add_text(")");
            3:       add_text(",");
            4:       add_text(" && ");
            5:       add_text("\t");
            6:       add_text("42");
            default: add_text(" || ");
        endcase
    endtask

    task automatic add_piece();
        case ($urandom_range(0, 9))
            0:       add_text("is");
            1:       add_text("not");
            2:       add_text("empty");
            3:       add_near_miss();
            4, 5:    add_ident();
            6:       add_quoted();
            7:       add_operator();
            8:       append_byte(8'($urandom_range(128, 255)));
            default: append_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    // Separator: mostly a blank, sometimes nothing so that tokens merge.
    task automatic add_sep();
        case ($urandom_range(0, 9))
            0, 1:    ;
            2:       add_quoted();
            3:       add_text("(");
            default: add_text(" ");
        endcase
    endtask

    // Keywords in order, with quoted text now and then between them.
    task automatic add_triple();
        add_text("is");
        add_sep();
        add_text("not");
        add_sep();
        add_text("empty");
    endtask

    task automatic build_expr();
        int n;
        int triple_at;
        if ($urandom_range(0, 99) < 12) begin
            // Noise: raw bytes of any value.
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                append_byte(8'($urandom_range(0, 255)));
        end else begin
            n         = $urandom_range(0, 4);
            triple_at = ($urandom_range(0, 99) < 45) ? $urandom_range(0, n) : -1;
            for (int i = 0; i < n; i++) begin
                if (i == triple_at) begin
                    add_triple();
                    add_sep();
                end
                add_piece();
                add_sep();
            end
            if (triple_at == n)
                add_triple();
        end
        if (expr_q.size() == 0)
            add_ident();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Identifiers ended by quotes, quoted text and an escaped quote between
        // the keywords, and the last keyword finishing on the final character.
        add_text("is");
        append_byte(CH_DQUOTE);
        add_text("q");
        append_byte(CH_DQUOTE);
        add_text("not");
        append_byte(CH_SQUOTE);
        append_byte(CH_BSLASH);
        append_byte(CH_SQUOTE);
        append_byte(CH_SQUOTE);
        add_text("empty");
        send_expr();

        // Byte extremes, then a quote left open at the final character.
        append_byte(8'h00);
        append_byte(8'hFF);
        append_byte(CH_SQUOTE);
        send_expr();

        // Identifier made of underscore, letter, hyphen and digit.
        add_text("_a-9");
        send_expr();

        while (items_sent < ITEM_TARGET) begin
            calm = (expr_count % 9 == 4);
            if (expr_count == HOLD_EXPR) begin
                // Hold the sender until every expected word has come out.
                s_valid <= 1'b0;
                do @(negedge aclk); while (words_in_flight != 0);
                @(posedge aclk);
            end
            build_expr();
            send_expr();
            expr_count++;
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        // Drain, then give the block time to show any stray word.
        do @(negedge aclk); while (words_in_flight != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
